>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while the asynchronous active-low reset is low
`define ASSERT_AR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/bbdt_pkg.sv
// ----------------------------------------------------------------------------
// bbdt_pkg
// Types, constants and helpers for the beam-break dwell tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package bbdt_pkg;

  localparam int GATES     = 8;
  localparam int MASK_W    = 8;
  localparam int TS_W      = 32;
  localparam int CNT_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int STAGE_W   = 3;
  localparam int QG_W      = 3;
  localparam int OG_W      = 3;
  localparam int GATE_W    = (GATES > 1) ? $clog2(GATES) : 1;
  localparam int TREE_LVL  = GATE_W;
  localparam int NPAD      = 1 << TREE_LVL;

  localparam logic [CFG_IDX_W-1:0] CFG_ARM_IGNORE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_AFTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_ONE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_TWO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_THREE = 3'd4;

  localparam logic [CFG_W-1:0] RST_ARM_IGNORE  = 16'd2000;
  localparam logic [CFG_W-1:0] RST_COUNT_AFTER = 16'd3000;
  localparam logic [CFG_W-1:0] RST_STAGE_ONE   = 16'd1000;
  localparam logic [CFG_W-1:0] RST_STAGE_TWO   = 16'd2000;
  localparam logic [CFG_W-1:0] RST_STAGE_THREE = 16'd3000;

  localparam logic [STAGE_W-1:0] STG_NONE  = 3'd0;
  localparam logic [STAGE_W-1:0] STG_ONE   = 3'd1;
  localparam logic [STAGE_W-1:0] STG_TWO   = 3'd2;
  localparam logic [STAGE_W-1:0] STG_THREE = 3'd3;
  localparam logic [STAGE_W-1:0] STG_SIREN = 3'd4;

  typedef struct packed {
    logic [TS_W-1:0]   now_ms;
    logic              armed;
    logic [MASK_W-1:0] broken_mask;
    logic              clear_counts;
    logic [QG_W-1:0]   query_gate;
  } in_t;

  typedef struct packed {
    logic [STAGE_W-1:0] stage;
    logic               any_interrupted;
    logic [OG_W-1:0]    worst_gate;
    logic [TS_W-1:0]    worst_ms;
    logic               in_ignore;
    logic [MASK_W-1:0]  counted_mask;
    logic [CNT_W-1:0]   query_count;
  } out_t;

  typedef struct packed {
    logic            en;
    logic            track;
    logic            brk;
    logic            clr;
    logic [TS_W-1:0] now;
  } lane_cmd_t;

  typedef struct packed {
    logic             act;
    logic             fired;
    logic [TS_W-1:0]  ms;
    logic [CNT_W-1:0] count;
  } lane_res_t;

  typedef struct packed {
    logic              vld;
    logic [GATE_W-1:0] gate;
    logic [TS_W-1:0]   ms;
  } cand_t;

  typedef struct packed {
    logic              in_ignore;
    logic [MASK_W-1:0] counted_mask;
    logic [CNT_W-1:0]  query_count;
  } side_t;

  typedef struct packed {
    logic [CFG_W-1:0] one;
    logic [CFG_W-1:0] two;
    logic [CFG_W-1:0] three;
  } thr_t;

  // lower index wins ties
  function automatic cand_t cand_pick(input cand_t a, input cand_t b);
    cand_t r;
    r = a;
    if (b.vld && (!a.vld || (b.ms > a.ms))) begin
      r = b;
    end
    return r;
  endfunction

  function automatic logic [STAGE_W-1:0] stage_of(input logic [TS_W-1:0] ms, input thr_t thr);
    logic [STAGE_W-1:0] s;
    priority if (ms < TS_W'(thr.one)) begin
      s = STG_ONE;
    end else if (ms < TS_W'(thr.two)) begin
      s = STG_TWO;
    end else if (ms < TS_W'(thr.three)) begin
      s = STG_THREE;
    end else begin
      s = STG_SIREN;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/beam_break_dwell_tracker.sv
// A result passes through the lane register, the tree register and the
// output register before it is offered.
// Throughput: one item per cycle unless stalled at the output; each gate lane
// updates its state on accept; the max tree and output register follow behind.
// Reset: gate state, arm state and pipeline valids cleared at once, config
// registers back to defaults; no clearing pass, input ready right after reset.
// ----------------------------------------------------------------------------
// beam_break_dwell_tracker
// Per-gate interruption tracking with dwell counting and escalation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module beam_break_dwell_tracker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bbdt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bbdt_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  bbdt_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bbdt_pkg::out_t                    out_data_o
);
  import bbdt_pkg::*;

  logic [CFG_W-1:0] arm_ignore_q, count_after_q;
  thr_t             thr_q;

  logic            last_armed_q;
  logic [TS_W-1:0] arm_time_q, arm_time_eff;
  logic            ignore, track, accept;

  lane_cmd_t                cmd [GATES];
  lane_res_t [GATES-1:0]    res;

  logic                     v1_q, m_ready, en1;
  cand_t [GATES-1:0]        s1_lanes_q;
  side_t                    s1_side_q;
  logic [GATES-1:0]         s1_act;
  logic [MASK_W-1:0]        cmask;
  logic [CNT_W-1:0]         qcount;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_ignore_q  <= RST_ARM_IGNORE;
      count_after_q <= RST_COUNT_AFTER;
      thr_q.one     <= RST_STAGE_ONE;
      thr_q.two     <= RST_STAGE_TWO;
      thr_q.three   <= RST_STAGE_THREE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ARM_IGNORE:  arm_ignore_q  <= cfg_data_i;
        CFG_COUNT_AFTER: count_after_q <= cfg_data_i;
        CFG_STAGE_ONE:   thr_q.one     <= cfg_data_i;
        CFG_STAGE_TWO:   thr_q.two     <= cfg_data_i;
        CFG_STAGE_THREE: thr_q.three   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en1        = !v1_q || m_ready;
  assign in_ready_o = en1;
  assign accept     = in_valid_i && en1;

  assign arm_time_eff = (in_data_i.armed && !last_armed_q) ? in_data_i.now_ms : arm_time_q;
  assign ignore = in_data_i.armed &&
                  ((in_data_i.now_ms - arm_time_eff) < TS_W'(arm_ignore_q));
  assign track  = in_data_i.armed && !ignore;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_armed_q <= 1'b0;
      arm_time_q   <= '0;
      v1_q         <= 1'b0;
    end else begin
      if (accept) begin
        last_armed_q <= in_data_i.armed;
        arm_time_q   <= arm_time_eff;
      end
      if (en1) v1_q <= in_valid_i;
    end
  end

  for (genvar g = 0; g < GATES; g++) begin : g_lane
    assign cmd[g].en    = accept;
    assign cmd[g].track = track;
    assign cmd[g].clr   = in_data_i.clear_counts;
    assign cmd[g].now   = in_data_i.now_ms;
    if (g < MASK_W) begin : g_brk
      assign cmd[g].brk  = in_data_i.broken_mask[g];
      assign cmask[g]    = res[g].fired;
    end else begin : g_nobrk
      assign cmd[g].brk  = 1'b0;
    end

    bbdt_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd[g]),
      .count_after_i (count_after_q),
      .res_o         (res[g])
    );

    assign s1_act[g] = s1_lanes_q[g].vld;
  end

  for (genvar m = GATES; m < MASK_W; m++) begin : g_mpad
    assign cmask[m] = 1'b0;
  end

  always_comb begin
    qcount = '0;
    for (int i = 0; i < GATES; i++) begin
      if (int'(in_data_i.query_gate) == i) begin
        qcount = res[i].count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < GATES; i++) begin
        s1_lanes_q[i].vld  <= res[i].act;
        s1_lanes_q[i].gate <= res[i].act ? GATE_W'(i) : '0;
        s1_lanes_q[i].ms   <= res[i].act ? res[i].ms : '0;
      end
      s1_side_q.in_ignore    <= ignore;
      s1_side_q.counted_mask <= cmask;
      s1_side_q.query_count  <= qcount;
    end
  end

  bbdt_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .ready_o (m_ready),
    .lanes_i (s1_lanes_q),
    .side_i  (s1_side_q),
    .thr_i   (thr_q),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  `ASSERT_AR(a_disarm_drops, clk_i, rst_ni,
             (accept && !in_data_i.armed) |=> (s1_act == '0),
             "lane active while disarmed")
  `ASSERT_AR(a_ignore_drops, clk_i, rst_ni,
             (v1_q && s1_side_q.in_ignore) |-> (s1_act == '0),
             "lane active inside ignore window")
  `ASSERT_AR(a_arm_edge, clk_i, rst_ni,
             (accept && in_data_i.armed && !last_armed_q) |=>
               (arm_time_q == $past(in_data_i.now_ms)),
             "arm time not captured on arming edge")

endmodule

`default_nettype wire

>>> rtl/core/bbdt_lane.sv
// ----------------------------------------------------------------------------
// bbdt_lane
// Per-gate tracker: interruption start, one-shot count event, saturating
// counter.
// ----------------------------------------------------------------------------
`default_nettype none

module bbdt_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bbdt_pkg::lane_cmd_t             cmd_i,
  input  logic [bbdt_pkg::CFG_W-1:0]      count_after_i,
  output bbdt_pkg::lane_res_t             res_o
);
  import bbdt_pkg::*;

  logic             active_q, active_d;
  logic             counted_q, counted_d;
  logic [TS_W-1:0]  since_q, since_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [TS_W-1:0]  ms;
  logic             fired;

  always_comb begin
    count_d   = cmd_i.clr ? '0 : count_q;
    active_d  = active_q;
    counted_d = counted_q;
    since_d   = since_q;
    fired     = 1'b0;
    ms        = '0;
    if (!cmd_i.track) begin
      active_d  = 1'b0;
      counted_d = 1'b0;
    end else if (cmd_i.brk) begin
      if (!active_q) begin
        active_d  = 1'b1;
        since_d   = cmd_i.now;
        counted_d = 1'b0;
      end
    end else begin
      active_d  = 1'b0;
      counted_d = 1'b0;
    end
    if (active_d) begin
      ms = cmd_i.now - since_d;
      if (!counted_d && (ms >= TS_W'(count_after_i))) begin
        if (count_d != '1) begin
          count_d = count_d + 1'b1;
        end
        counted_d = 1'b1;
        fired     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      counted_q <= 1'b0;
      since_q   <= '0;
      count_q   <= '0;
    end else if (cmd_i.en) begin
      active_q  <= active_d;
      counted_q <= counted_d;
      since_q   <= since_d;
      count_q   <= count_d;
    end
  end

  assign res_o.act   = active_d;
  assign res_o.fired = fired;
  assign res_o.ms    = ms;
  assign res_o.count = count_d;

endmodule

`default_nettype wire

>>> rtl/core/bbdt_merge.sv
// ----------------------------------------------------------------------------
// bbdt_merge
// Registered max tree over the lanes, escalation stage and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bbdt_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  bbdt_pkg::cand_t [bbdt_pkg::GATES-1:0] lanes_i,
  input  bbdt_pkg::side_t                     side_i,
  input  bbdt_pkg::thr_t                      thr_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output bbdt_pkg::out_t                      data_o
);
  import bbdt_pkg::*;

  cand_t tree [TREE_LVL][NPAD];

  logic        v2_q, v3_q;
  logic        en2, en3;
  cand_t [1:0] c2_q;
  side_t       side2_q;
  out_t        out_q, out_d;

  logic               take_b;
  cand_t              w;
  logic [STAGE_W-1:0] st0, st1;

  always_comb begin
    tree = '{default: '0};
    for (int i = 0; i < GATES; i++) begin
      tree[0][i] = lanes_i[i];
    end
    for (int l = 0; l < TREE_LVL - 1; l++) begin
      for (int p = 0; p < (NPAD >> (l + 1)); p++) begin
        tree[l+1][p] = cand_pick(tree[l][2*p], tree[l][2*p+1]);
      end
    end
  end

  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign ready_o = en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en2) v2_q <= valid_i;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && valid_i) begin
      c2_q[0] <= tree[TREE_LVL-1][0];
      c2_q[1] <= tree[TREE_LVL-1][1];
      side2_q <= side_i;
    end
    if (en3 && v2_q) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    take_b = c2_q[1].vld && (!c2_q[0].vld || (c2_q[1].ms > c2_q[0].ms));
    w      = take_b ? c2_q[1] : c2_q[0];
    st0    = stage_of(c2_q[0].ms, thr_i);
    st1    = stage_of(c2_q[1].ms, thr_i);
    out_d.stage           = w.vld ? (take_b ? st1 : st0) : STG_NONE;
    out_d.any_interrupted = w.vld;
    out_d.worst_gate      = w.vld ? OG_W'(w.gate) : '0;
    out_d.worst_ms        = w.vld ? w.ms : '0;
    out_d.in_ignore       = side2_q.in_ignore;
    out_d.counted_mask    = side2_q.counted_mask;
    out_d.query_count     = side2_q.query_count;
  end

  assign valid_o = v3_q;
  assign data_o  = out_q;

  `ASSERT_AR(a_stage_any, clk_i, rst_ni,
             v3_q |-> (out_q.any_interrupted == (out_q.stage != STG_NONE)),
             "stage disagrees with any_interrupted")
  `ASSERT_AR(a_ignore_quiet, clk_i, rst_ni,
             (v3_q && out_q.in_ignore) |-> !out_q.any_interrupted,
             "interruption reported inside ignore window")
  `ASSERT_ALWAYS(a_rst_empty, clk_i,
                 !rst_ni |-> (!v2_q && !v3_q),
                 "pipeline holds data under reset")

endmodule

`default_nettype wire

>>> tb/sv/beam_break_dwell_tracker_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beam_break_dwell_tracker_check
// Watches the register port and both transfer channels of the dwell tracker.
// Keeps its own copy of the gate tracking state and the thresholds, works out
// the report for every accepted poll tick and compares each report, field by
// field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module beam_break_dwell_tracker_check
  import bbdt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_t                  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_t                 out_data_i,
  output int unsigned          err_count_o,
  output int unsigned          pending_o,
  output int unsigned          checked_o
);

  logic [CFG_W-1:0] ign_win    = RST_ARM_IGNORE;
  logic [CFG_W-1:0] dwell_thr  = RST_COUNT_AFTER;
  logic [CFG_W-1:0] thr_one    = RST_STAGE_ONE;
  logic [CFG_W-1:0] thr_two    = RST_STAGE_TWO;
  logic [CFG_W-1:0] thr_three  = RST_STAGE_THREE;

  logic             trk_on    [GATES];
  logic [TS_W-1:0]  trk_since [GATES];
  logic             trk_done  [GATES];
  logic [CNT_W-1:0] trk_count [GATES];
  logic             prev_armed;
  logic [TS_W-1:0]  armed_at;

  out_t        reports_q [$];
  out_t        want;
  logic [6:0]  diff;
  int unsigned errs    = 0;
  int unsigned checked = 0;

  initial begin
    err_count_o = 0;
    pending_o   = 0;
    checked_o   = 0;
  end

  function automatic out_t track_tick(input in_t t);
    out_t            r;
    logic [TS_W-1:0] dwell;
    r = '0;
    if (t.clear_counts) begin
      for (int g = 0; g < GATES; g++) trk_count[g] = '0;
    end
    if (t.armed && !prev_armed) armed_at = t.now_ms;
    prev_armed  = t.armed;
    r.in_ignore = t.armed && ((t.now_ms - armed_at) < TS_W'(ign_win));
    if (!t.armed || r.in_ignore) begin
      for (int g = 0; g < GATES; g++) begin
        trk_on[g]   = 1'b0;
        trk_done[g] = 1'b0;
      end
    end else begin
      for (int g = 0; g < GATES; g++) begin
        if (g < MASK_W && t.broken_mask[g]) begin
          if (!trk_on[g]) begin
            trk_on[g]    = 1'b1;
            trk_since[g] = t.now_ms;
            trk_done[g]  = 1'b0;
          end
        end else begin
          trk_on[g]   = 1'b0;
          trk_done[g] = 1'b0;
        end
        if (trk_on[g]) begin
          dwell = t.now_ms - trk_since[g];
          if (!trk_done[g] && dwell >= TS_W'(dwell_thr)) begin
            if (trk_count[g] != '1) trk_count[g] = trk_count[g] + 1'b1;
            trk_done[g]        = 1'b1;
            r.counted_mask[g]  = 1'b1;
          end
          // strict compare keeps the lowest gate on ties
          if (!r.any_interrupted || dwell > r.worst_ms) begin
            r.any_interrupted = 1'b1;
            r.worst_gate      = OG_W'(g);
            r.worst_ms        = dwell;
          end
        end
      end
      if (r.any_interrupted) begin
        if (r.worst_ms < TS_W'(thr_one))        r.stage = STG_ONE;
        else if (r.worst_ms < TS_W'(thr_two))   r.stage = STG_TWO;
        else if (r.worst_ms < TS_W'(thr_three)) r.stage = STG_THREE;
        else                                    r.stage = STG_SIREN;
      end
    end
    r.query_count = (int'(t.query_gate) < GATES) ? trk_count[t.query_gate] : '0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < GATES; g++) begin
        trk_on[g]    = 1'b0;
        trk_since[g] = '0;
        trk_done[g]  = 1'b0;
        trk_count[g] = '0;
      end
      prev_armed = 1'b0;
      armed_at   = '0;
      ign_win    = RST_ARM_IGNORE;
      dwell_thr  = RST_COUNT_AFTER;
      thr_one    = RST_STAGE_ONE;
      thr_two    = RST_STAGE_TWO;
      thr_three  = RST_STAGE_THREE;
      reports_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ARM_IGNORE:  ign_win   = cfg_data_i;
          CFG_COUNT_AFTER: dwell_thr = cfg_data_i;
          CFG_STAGE_ONE:   thr_one   = cfg_data_i;
          CFG_STAGE_TWO:   thr_two   = cfg_data_i;
          CFG_STAGE_THREE: thr_three = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) reports_q.push_back(track_tick(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (reports_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("%0t: report with none pending: %p", $realtime, out_data_i);
        end else begin
          want = reports_q.pop_front();
          diff = {want.stage !== out_data_i.stage,
                  want.any_interrupted !== out_data_i.any_interrupted,
                  want.worst_gate !== out_data_i.worst_gate,
                  want.worst_ms !== out_data_i.worst_ms,
                  want.in_ignore !== out_data_i.in_ignore,
                  want.counted_mask !== out_data_i.counted_mask,
                  want.query_count !== out_data_i.query_count};
          if (diff != '0) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: report %0d mismatch, fields %b", $realtime, checked, diff);
              $display("  want stg=%0d any=%0b wg=%0d ms=%0d ign=%0b cm=%02h qc=%0d",
                       want.stage, want.any_interrupted, want.worst_gate, want.worst_ms,
                       want.in_ignore, want.counted_mask, want.query_count);
              $display("  got  stg=%0d any=%0b wg=%0d ms=%0d ign=%0b cm=%02h qc=%0d",
                       out_data_i.stage, out_data_i.any_interrupted, out_data_i.worst_gate,
                       out_data_i.worst_ms, out_data_i.in_ignore, out_data_i.counted_mask,
                       out_data_i.query_count);
            end
          end
          checked++;
        end
      end
      err_count_o <= errs;
      pending_o   <= reports_q.size();
      checked_o   <= checked;
    end
  end

endmodule

>>> tb/sv/beam_break_dwell_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beam_break_dwell_tracker_test
// Drives poll ticks into the dwell tracker: a directed walk through arming,
// the ignore window, every escalation stage, counting, clearing and timestamp
// wrap, then random phases under several threshold settings. Sender bursts
// and receiver stalls vary throughout; the checker module does the compare.
// ----------------------------------------------------------------------------
module beam_break_dwell_tracker_test;
  import bbdt_pkg::*;

  typedef enum logic [1:0] {RX_FREE, RX_HALF, RX_SPARSE, RX_STALLS} rx_mode_e;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned PHASE_TICKS = 175;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;

  int unsigned err_count;
  int unsigned pending;
  int unsigned checked;

  int unsigned cycles     = 0;
  int unsigned sent       = 0;
  int unsigned settings   = 1;
  int unsigned burst_left = 0;

  rx_mode_e    rx_mode = RX_FREE;
  int unsigned rx_span = 0;
  int unsigned rx_hold = 0;

  logic [TS_W-1:0]   now_r   = '0;
  logic              armed_r = 1'b0;
  logic [MASK_W-1:0] mask_r  = '0;

  beam_break_dwell_tracker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  beam_break_dwell_tracker_check u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports pending", cycles, pending);
      $display("beam_break_dwell_tracker_test: errors");
      $finish;
    end
  end

  // receiver back-pressure, mode changes when a random span runs out
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_span <= $urandom_range(16, 200);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold != 0) begin
          out_ready <= 1'b0;
          rx_hold   <= rx_hold - 1;
        end else if ($urandom_range(0, 9) == 0) begin
          out_ready <= 1'b0;
          rx_hold   <= $urandom_range(4, 24);
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  task automatic send_tick(input in_t t);
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic tick(input logic [TS_W-1:0] now, input logic arm,
                      input logic [MASK_W-1:0] mask, input logic clr,
                      input logic [QG_W-1:0] q);
    in_t t;
    t.now_ms       = now;
    t.armed        = arm;
    t.broken_mask  = mask;
    t.clear_counts = clr;
    t.query_gate   = q;
    now_r   = now;
    armed_r = arm;
    mask_r  = mask;
    send_tick(t);
  endtask

  // time moves forward mostly in steps near the thresholds, with rare jumps
  task automatic random_tick(input int unsigned scale);
    in_t         t;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      t.now_ms       = $urandom;
      t.armed        = 1'($urandom_range(0, 1));
      t.broken_mask  = MASK_W'($urandom);
      t.clear_counts = 1'($urandom_range(0, 1));
      t.query_gate   = QG_W'($urandom);
      send_tick(t);
    end else begin
      if (r < 9)       now_r = now_r;
      else if (r < 65) now_r = now_r + $urandom_range(0, scale);
      else if (r < 96) now_r = now_r + $urandom_range(0, 4 * scale);
      else             now_r = now_r + $urandom;
      if (armed_r) armed_r = ($urandom_range(0, 199) > 2);
      else         armed_r = ($urandom_range(0, 99) < 15);
      if ($urandom_range(0, 99) < 8) begin
        mask_r = MASK_W'($urandom);
      end else begin
        for (int g = 0; g < MASK_W; g++) begin
          if ($urandom_range(0, 9) == 0) mask_r[g] = ~mask_r[g];
        end
      end
      tick(now_r, armed_r, mask_r, ($urandom_range(0, 49) == 0), QG_W'($urandom));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] ign, cnt, s1, s2, s3,
                           input int unsigned scale);
    logic [CFG_IDX_W-1:0] regs [5];
    logic [CFG_W-1:0]     vals [5];
    regs = '{CFG_ARM_IGNORE, CFG_COUNT_AFTER, CFG_STAGE_ONE, CFG_STAGE_TWO, CFG_STAGE_THREE};
    vals = '{ign, cnt, s1, s2, s3};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
    repeat (PHASE_TICKS) random_tick(scale);
  endtask

  initial begin
    // falling edge at time zero so the asynchronous resets take effect at once
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset thresholds: ignore 2000, count 3000, stages 1000/2000/3000
    tick(32'd0,    1'b0, 8'hFF, 1'b0, 3'd0);
    tick(32'd500,  1'b0, 8'h00, 1'b1, 3'd7);
    tick(32'd1000, 1'b1, 8'hFF, 1'b0, 3'd1);
    tick(32'd2999, 1'b1, 8'hFF, 1'b0, 3'd2);
    tick(32'd3000, 1'b1, 8'h81, 1'b0, 3'd3);
    tick(32'd3999, 1'b1, 8'h83, 1'b0, 3'd0);
    tick(32'd4000, 1'b1, 8'h83, 1'b0, 3'd0);
    tick(32'd5000, 1'b1, 8'h83, 1'b0, 3'd7);
    tick(32'd6000, 1'b1, 8'h83, 1'b0, 3'd0);
    tick(32'd6001, 1'b1, 8'h82, 1'b0, 3'd7);
    tick(32'd6999, 1'b1, 8'h82, 1'b0, 3'd1);
    tick(32'd7000, 1'b1, 8'h83, 1'b1, 3'd7);
    tick(32'd7000, 1'b1, 8'hFF, 1'b0, 3'd3);
    tick(32'd7500, 1'b0, 8'hFF, 1'b0, 3'd1);
    // re-arm just below the timestamp wrap
    tick(32'hFFFF_F000, 1'b1, 8'hFF, 1'b0, 3'd0);
    tick(32'hFFFF_FFFF, 1'b1, 8'h55, 1'b0, 3'd0);
    tick(32'h0000_0BB7, 1'b1, 8'h55, 1'b0, 3'd2);
    tick(32'h0000_0BB8, 1'b1, 8'hAA, 1'b0, 3'd4);
    tick(32'h8000_0000, 1'b1, 8'hAA, 1'b0, 3'd5);
    tick(32'h8000_0000, 1'b1, 8'h00, 1'b0, 3'd6);
    tick(32'h8000_0001, 1'b1, 8'hFF, 1'b1, 3'd7);
    tick(32'h8000_0002, 1'b0, 8'h00, 1'b0, 3'd4);

    run_phase(16'd20, 16'd30, 16'd10, 16'd20, 16'd30, 8);
    run_phase('0, '0, '0, '0, '0, 4);
    run_phase('1, '1, '1, '1, '1, 20000);
    run_phase(16'd5, 16'd100, 16'd60, 16'd40, 16'd200, 40);
    run_phase(CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 300)),
              CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 300)),
              CFG_W'($urandom_range(0, 300)), 50);
    run_phase(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
              CFG_W'($urandom), CFG_W'($urandom), 16384);
    run_phase(RST_ARM_IGNORE, RST_COUNT_AFTER, RST_STAGE_ONE, RST_STAGE_TWO,
              RST_STAGE_THREE, 700);

    drain();
    repeat (8) @(posedge clk);
    $display("%0d poll ticks sent under %0d threshold settings, %0d reports compared",
             sent, settings, checked);
    if (err_count == 0 && pending == 0) begin
      $display("beam_break_dwell_tracker_test: clean");
    end else begin
      $display("%0d mismatches, %0d reports missing", err_count, pending);
      $display("beam_break_dwell_tracker_test: errors");
    end
    $finish;
  end

endmodule
